FILE: rtl/rlsf_pkg.sv
// Shared constants and register codes of the fan speed lag and slew filter.
`default_nettype none

package rlsf_pkg;

    localparam int NUM_CHANNELS_DEF    = 8;
    localparam int ALPHA_FRAC_BITS_DEF = 12;

    localparam int CHANNEL_W   = 3;
    localparam int RPM_W       = 16;
    localparam int TIME_W      = 32;
    localparam int IN_DATA_W   = 56;
    localparam int OUT_DATA_W  = 24;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int MULT_W      = 8;

    localparam int LIM_DIVISOR = 1000;
    localparam int LIM_Q_W     = 17;
    localparam int LIM_REM_W   = 10;
    localparam logic [TIME_W-1:0] LIM_BOUND = TIME_W'(LIM_DIVISOR * (1 << LIM_Q_W));

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LAG_TAU    = 3'd0,
        REG_SLEW       = 3'd1,
        REG_RELOAD_GAP = 3'd2,
        REG_UNIT_THR   = 3'd3,
        REG_UNIT_MULT  = 3'd4,
        REG_ZERO_FLOOR = 3'd5
    } cfg_reg_t;

    localparam logic [RPM_W-1:0]  LAG_TAU_RESET    = 16'd1000;
    localparam logic [RPM_W-1:0]  SLEW_RESET       = 16'd1500;
    localparam logic [RPM_W-1:0]  RELOAD_GAP_RESET = 16'd5000;
    localparam logic [RPM_W-1:0]  UNIT_THR_RESET   = 16'd500;
    localparam logic [MULT_W-1:0] UNIT_MULT_RESET  = 8'd100;
    localparam logic [RPM_W-1:0]  ZERO_FLOOR_RESET = 16'd50;

endpackage

`default_nettype wire

FILE: rtl/rpm_lag_slew_filter.sv
// Top level of the per-channel fan speed lag filter with slew-rate limit.
`default_nettype none

// Filters fan tachometer readings, one first-order lag per channel, with the
// step per sample limited by a slew rate. Each accepted reading gives one
// result: the channel and its filtered rpm. Readings are taken one at a time;
// a reading that goes through the full lag update passes bit-serial
// multiplication (unit scaling one bit a cycle, slew times gap two bits a
// cycle), a decision state, a divide state in which the restoring divider
// for alpha runs beside the divider by 1000 for the slew limit, with the
// delta times alpha product built from the quotient bits as they appear,
// then step, apply and write states. A reading that snaps to zero, reloads,
// has no gap or no difference goes from the decision straight to write; a
// channel number of NUM_CHANNELS or more goes straight to write. The result
// register lets the next reading in while a result still waits. Configuration
// writes are taken in any cycle.
module rpm_lag_slew_filter #(
    parameter int NUM_CHANNELS    = rlsf_pkg::NUM_CHANNELS_DEF,
    parameter int ALPHA_FRAC_BITS = rlsf_pkg::ALPHA_FRAC_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [rlsf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [rlsf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // fan_channel[2:0], raw_reading[18:3], now_ms[50:19], zero[55:51]
    input  wire logic [rlsf_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // out_channel[2:0], filtered_rpm[18:3], zero[23:19]
    output logic [rlsf_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);

    localparam int CH_W        = rlsf_pkg::CHANNEL_W;
    localparam int RPM_W       = rlsf_pkg::RPM_W;
    localparam int TIME_W      = rlsf_pkg::TIME_W;
    localparam int MULT_W      = rlsf_pkg::MULT_W;
    localparam int LIM_Q_W     = rlsf_pkg::LIM_Q_W;
    localparam int LIM_REM_W   = rlsf_pkg::LIM_REM_W;
    localparam int CH_IDX_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int F           = ALPHA_FRAC_BITS;
    localparam int ALPHA_ITERS = F + 1;
    localparam int DIV_ITERS   = (ALPHA_ITERS > LIM_Q_W) ? ALPHA_ITERS : LIM_Q_W;
    localparam int CNT_W       = $clog2(DIV_ITERS);
    localparam int ACC_W       = RPM_W + F;
    localparam int SCALE_W     = RPM_W + MULT_W;
    localparam int DSOR_W      = RPM_W + 1;
    localparam int STEP_W      = RPM_W + 1;
    localparam int PAD_W       = rlsf_pkg::OUT_DATA_W - CH_W - RPM_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DECIDE,
        ST_DIV,
        ST_STEP,
        ST_APPLY,
        ST_WRITE
    } state_t;

    logic [RPM_W-1:0]  lag_tau_reg;
    logic [RPM_W-1:0]  slew_reg;
    logic [RPM_W-1:0]  reload_gap_reg;
    logic [RPM_W-1:0]  unit_thr_reg;
    logic [MULT_W-1:0] unit_mult_reg;
    logic [RPM_W-1:0]  zero_floor_reg;

    logic [RPM_W-1:0]  filter_value_reg [NUM_CHANNELS];
    logic [TIME_W-1:0] last_time_reg    [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] channel_seen_reg;

    state_t               state_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CH_W-1:0]      ch_reg;
    logic [CH_IDX_W-1:0]  idx_reg;
    logic [RPM_W-1:0]     raw_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [TIME_W-1:0]    dt_reg;
    logic [RPM_W-1:0]     fv_reg;
    logic                 seen_reg;
    logic [MULT_W-1:0]    mult_sh_reg;
    logic [RPM_W-1:0]     dt_sh_reg;
    logic [SCALE_W-1:0]   scale_acc_reg;
    logic [TIME_W-1:0]    slew_acc_reg;
    logic [RPM_W-1:0]     mag_reg;
    logic                 neg_reg;
    logic [DSOR_W-1:0]    dsor_reg;
    logic [DSOR_W-1:0]    rem_a_reg;
    logic                 abit_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic [LIM_REM_W-1:0] rem_l_reg;
    logic [LIM_Q_W-1:0]   p_sh_reg;
    logic [LIM_Q_W-1:0]   q_lim_reg;
    logic                 no_clamp_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [RPM_W-1:0]     new_fv_reg;
    logic                 wr_fv_reg;
    logic                 wr_lt_reg;
    logic                 out_valid_reg;
    logic [CH_W-1:0]      out_ch_reg;
    logic [RPM_W-1:0]     out_rpm_reg;

    logic [CH_W-1:0]          in_ch;
    logic [RPM_W-1:0]         in_raw;
    logic [TIME_W-1:0]        in_now;
    logic [CH_IDX_W+CH_W-1:0] in_ch_ext;
    logic [CH_IDX_W-1:0]      in_idx;
    logic                     in_valid_ch;
    logic                     in_xfer;

    logic [SCALE_W-1:0]   scale_add;
    logic [RPM_W+1:0]     slew_part;
    logic [RPM_W-1:0]     scaled_rpm;
    logic                 rpm_ge;
    logic [DSOR_W:0]      a_trial;
    logic                 a_fit;
    logic [DSOR_W:0]      a_diff;
    logic [LIM_REM_W:0]   l_trial;
    logic                 l_fit;
    logic [LIM_REM_W:0]   l_diff;
    logic                 frac_nz;
    logic [STEP_W-1:0]    s_raw;
    logic [STEP_W-1:0]    s_min;
    logic [STEP_W-1:0]    s_lim;
    logic [STEP_W-1:0]    s_clamped;
    logic [STEP_W-1:0]    fv_ext;
    logic [STEP_W-1:0]    fv_sum;
    logic                 out_free;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_rpm_reg, out_ch_reg};

    assign in_ch       = s_axis_tdata[CH_W-1:0];
    assign in_raw      = s_axis_tdata[CH_W+RPM_W-1:CH_W];
    assign in_now      = s_axis_tdata[CH_W+RPM_W+TIME_W-1:CH_W+RPM_W];
    assign in_ch_ext   = {{CH_IDX_W{1'b0}}, in_ch};
    assign in_idx      = in_ch_ext[CH_IDX_W-1:0];
    assign in_valid_ch = (in_ch_ext < (CH_IDX_W + CH_W)'(NUM_CHANNELS));
    assign in_xfer     = s_axis_tvalid && s_axis_tready;
    assign out_free    = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        scale_add = mult_sh_reg[MULT_W-1] ? {{MULT_W{1'b0}}, raw_reg} : '0;
        slew_part = (dt_sh_reg[RPM_W-1] ? {1'b0, slew_reg, 1'b0} : '0)
                  + (dt_sh_reg[RPM_W-2] ? {2'b00, slew_reg} : '0);

        if (raw_reg != '0 && raw_reg < unit_thr_reg)
        begin
            scaled_rpm = (|scale_acc_reg[SCALE_W-1:RPM_W]) ? '1 : scale_acc_reg[RPM_W-1:0];
        end
        else
        begin
            scaled_rpm = raw_reg;
        end
        rpm_ge = (scaled_rpm >= fv_reg);

        a_trial = {rem_a_reg, abit_reg};
        a_fit   = (a_trial >= {1'b0, dsor_reg});
        a_diff  = a_fit ? (a_trial - {1'b0, dsor_reg}) : a_trial;

        l_trial = {rem_l_reg, p_sh_reg[LIM_Q_W-1]};
        l_fit   = (l_trial >= (LIM_REM_W + 1)'(rlsf_pkg::LIM_DIVISOR));
        l_diff  = l_fit ? (l_trial - (LIM_REM_W + 1)'(rlsf_pkg::LIM_DIVISOR)) : l_trial;

        frac_nz   = |acc_reg[F-1:0];
        s_raw     = {1'b0, acc_reg[ACC_W-1:F]} + {{RPM_W{1'b0}}, neg_reg & frac_nz};
        s_min     = (s_raw == '0) ? STEP_W'(1) : s_raw;
        s_lim     = (q_lim_reg == '0) ? STEP_W'(1) : q_lim_reg;
        s_clamped = (!no_clamp_reg && s_min > s_lim) ? s_lim : s_min;

        fv_ext = {1'b0, fv_reg};
        fv_sum = fv_ext + step_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lag_tau_reg    <= rlsf_pkg::LAG_TAU_RESET;
            slew_reg       <= rlsf_pkg::SLEW_RESET;
            reload_gap_reg <= rlsf_pkg::RELOAD_GAP_RESET;
            unit_thr_reg   <= rlsf_pkg::UNIT_THR_RESET;
            unit_mult_reg  <= rlsf_pkg::UNIT_MULT_RESET;
            zero_floor_reg <= rlsf_pkg::ZERO_FLOOR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (rlsf_pkg::cfg_reg_t'(cfg_index))
                rlsf_pkg::REG_LAG_TAU:    lag_tau_reg    <= cfg_data;
                rlsf_pkg::REG_SLEW:       slew_reg       <= cfg_data;
                rlsf_pkg::REG_RELOAD_GAP: reload_gap_reg <= cfg_data;
                rlsf_pkg::REG_UNIT_THR:   unit_thr_reg   <= cfg_data;
                rlsf_pkg::REG_UNIT_MULT:  unit_mult_reg  <= cfg_data[MULT_W-1:0];
                rlsf_pkg::REG_ZERO_FLOOR: zero_floor_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                filter_value_reg[i] <= '0;
                last_time_reg[i]    <= '0;
            end
            channel_seen_reg <= '0;
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            ch_reg           <= '0;
            idx_reg          <= '0;
            raw_reg          <= '0;
            now_reg          <= '0;
            dt_reg           <= '0;
            fv_reg           <= '0;
            seen_reg         <= 1'b0;
            mult_sh_reg      <= '0;
            dt_sh_reg        <= '0;
            scale_acc_reg    <= '0;
            slew_acc_reg     <= '0;
            mag_reg          <= '0;
            neg_reg          <= 1'b0;
            dsor_reg         <= '0;
            rem_a_reg        <= '0;
            abit_reg         <= 1'b0;
            acc_reg          <= '0;
            rem_l_reg        <= '0;
            p_sh_reg         <= '0;
            q_lim_reg        <= '0;
            no_clamp_reg     <= 1'b0;
            step_reg         <= '0;
            new_fv_reg       <= '0;
            wr_fv_reg        <= 1'b0;
            wr_lt_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_ch_reg       <= '0;
            out_rpm_reg      <= '0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready && state_reg != ST_WRITE)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        ch_reg        <= in_ch;
                        idx_reg       <= in_idx;
                        raw_reg       <= in_raw;
                        now_reg       <= in_now;
                        fv_reg        <= filter_value_reg[in_idx];
                        seen_reg      <= channel_seen_reg[in_idx];
                        dt_reg        <= in_now - last_time_reg[in_idx];
                        dt_sh_reg     <= in_now[RPM_W-1:0] - last_time_reg[in_idx][RPM_W-1:0];
                        mult_sh_reg   <= unit_mult_reg;
                        scale_acc_reg <= '0;
                        slew_acc_reg  <= '0;
                        cnt_reg       <= '0;
                        if (in_valid_ch)
                        begin
                            state_reg <= ST_MUL;
                        end
                        else
                        begin
                            new_fv_reg <= '0;
                            wr_fv_reg  <= 1'b0;
                            wr_lt_reg  <= 1'b0;
                            state_reg  <= ST_WRITE;
                        end
                    end
                end

                ST_MUL:
                begin
                    scale_acc_reg <= {scale_acc_reg[SCALE_W-2:0], 1'b0} + scale_add;
                    slew_acc_reg  <= {slew_acc_reg[TIME_W-3:0], 2'b00}
                                   + {{(TIME_W-RPM_W-2){1'b0}}, slew_part};
                    mult_sh_reg   <= {mult_sh_reg[MULT_W-2:0], 1'b0};
                    dt_sh_reg     <= {dt_sh_reg[RPM_W-3:0], 2'b00};
                    cnt_reg       <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(MULT_W - 1))
                    begin
                        state_reg <= ST_DECIDE;
                    end
                end

                ST_DECIDE:
                begin
                    cnt_reg      <= '0;
                    mag_reg      <= rpm_ge ? (scaled_rpm - fv_reg) : (fv_reg - scaled_rpm);
                    neg_reg      <= !rpm_ge;
                    dsor_reg     <= {1'b0, lag_tau_reg} + {1'b0, dt_reg[RPM_W-1:0]};
                    rem_a_reg    <= {2'b00, dt_reg[RPM_W-1:1]};
                    abit_reg     <= dt_reg[0];
                    acc_reg      <= '0;
                    rem_l_reg    <= slew_acc_reg[LIM_Q_W+LIM_REM_W-1:LIM_Q_W];
                    p_sh_reg     <= slew_acc_reg[LIM_Q_W-1:0];
                    q_lim_reg    <= '0;
                    no_clamp_reg <= (slew_acc_reg >= rlsf_pkg::LIM_BOUND);
                    if (scaled_rpm < zero_floor_reg)
                    begin
                        new_fv_reg <= '0;
                        wr_fv_reg  <= 1'b1;
                        wr_lt_reg  <= 1'b1;
                        state_reg  <= ST_WRITE;
                    end
                    else if (!seen_reg || dt_reg > {{(TIME_W-RPM_W){1'b0}}, reload_gap_reg})
                    begin
                        new_fv_reg <= scaled_rpm;
                        wr_fv_reg  <= 1'b1;
                        wr_lt_reg  <= 1'b1;
                        state_reg  <= ST_WRITE;
                    end
                    else if (dt_reg == '0)
                    begin
                        new_fv_reg <= fv_reg;
                        wr_fv_reg  <= 1'b0;
                        wr_lt_reg  <= 1'b0;
                        state_reg  <= ST_WRITE;
                    end
                    else if (scaled_rpm == fv_reg)
                    begin
                        new_fv_reg <= fv_reg;
                        wr_fv_reg  <= 1'b0;
                        wr_lt_reg  <= 1'b1;
                        state_reg  <= ST_WRITE;
                    end
                    else
                    begin
                        wr_fv_reg <= 1'b1;
                        wr_lt_reg <= 1'b1;
                        state_reg <= ST_DIV;
                    end
                end

                ST_DIV:
                begin
                    if (cnt_reg < CNT_W'(ALPHA_ITERS))
                    begin
                        rem_a_reg <= a_diff[DSOR_W-1:0];
                        abit_reg  <= 1'b0;
                        acc_reg   <= {acc_reg[ACC_W-2:0], 1'b0}
                                   + (a_fit ? {{F{1'b0}}, mag_reg} : '0);
                    end
                    if (cnt_reg < CNT_W'(LIM_Q_W))
                    begin
                        rem_l_reg <= l_diff[LIM_REM_W-1:0];
                        p_sh_reg  <= {p_sh_reg[LIM_Q_W-2:0], 1'b0};
                        q_lim_reg <= {q_lim_reg[LIM_Q_W-2:0], l_fit};
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(DIV_ITERS - 1))
                    begin
                        state_reg <= ST_STEP;
                    end
                end

                ST_STEP:
                begin
                    step_reg  <= s_clamped;
                    state_reg <= ST_APPLY;
                end

                ST_APPLY:
                begin
                    if (neg_reg)
                    begin
                        new_fv_reg <= (fv_ext < step_reg) ? '0 : (fv_reg - step_reg[RPM_W-1:0]);
                    end
                    else
                    begin
                        new_fv_reg <= fv_sum[RPM_W] ? '1 : fv_sum[RPM_W-1:0];
                    end
                    state_reg <= ST_WRITE;
                end

                ST_WRITE:
                begin
                    if (out_free)
                    begin
                        if (wr_fv_reg)
                        begin
                            filter_value_reg[idx_reg] <= new_fv_reg;
                        end
                        if (wr_lt_reg)
                        begin
                            last_time_reg[idx_reg]    <= now_reg;
                            channel_seen_reg[idx_reg] <= 1'b1;
                        end
                        out_valid_reg <= 1'b1;
                        out_ch_reg    <= ch_reg;
                        out_rpm_reg   <= new_fv_reg;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: sim/tb.sv
// Testbench for rpm_lag_slew_filter: directed and random fan readings checked against a predictor.
`timescale 1ns / 1ps

module tb;

    localparam int FRAC_BITS        = rlsf_pkg::ALPHA_FRAC_BITS_DEF;
    localparam int NUM_CHANNELS_DEF = rlsf_pkg::NUM_CHANNELS_DEF;
    localparam int CHANNEL_W        = rlsf_pkg::CHANNEL_W;
    localparam int RPM_W            = rlsf_pkg::RPM_W;
    localparam int TIME_W           = rlsf_pkg::TIME_W;
    localparam int MULT_W           = rlsf_pkg::MULT_W;
    localparam int CFG_INDEX_W      = rlsf_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W       = rlsf_pkg::CFG_DATA_W;
    localparam int IN_DATA_W        = rlsf_pkg::IN_DATA_W;
    localparam int OUT_DATA_W       = rlsf_pkg::OUT_DATA_W;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [CHANNEL_W-1:0] channel;
        logic [RPM_W-1:0]     rpm;
    } fan_speed_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;

    logic [RPM_W-1:0]  lag_tau_ms;
    logic [RPM_W-1:0]  slew_rate;
    logic [RPM_W-1:0]  reload_gap;
    logic [RPM_W-1:0]  unit_thr;
    logic [MULT_W-1:0] unit_mult;
    logic [RPM_W-1:0]  zero_floor;

    logic [RPM_W-1:0]  speed_mem [NUM_CHANNELS_DEF];
    logic [TIME_W-1:0] stamp_mem [NUM_CHANNELS_DEF];
    logic              seen_mem  [NUM_CHANNELS_DEF];

    fan_speed_t pending_speeds[$];
    int         errors   = 0;
    bit         src_calm = 1'b0;
    bit         sink_calm = 1'b0;

    rpm_lag_slew_filter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 clk = ~clk;

    function automatic void clear_filters();
        lag_tau_ms = rlsf_pkg::LAG_TAU_RESET;
        slew_rate  = rlsf_pkg::SLEW_RESET;
        reload_gap = rlsf_pkg::RELOAD_GAP_RESET;
        unit_thr   = rlsf_pkg::UNIT_THR_RESET;
        unit_mult  = rlsf_pkg::UNIT_MULT_RESET;
        zero_floor = rlsf_pkg::ZERO_FLOOR_RESET;
        for (int i = 0; i < NUM_CHANNELS_DEF; i++)
        begin
            speed_mem[i] = '0;
            stamp_mem[i] = '0;
            seen_mem[i]  = 1'b0;
        end
    endfunction

    function automatic fan_speed_t filter_reading(logic [CHANNEL_W-1:0] ch,
                                                  logic [RPM_W-1:0] raw,
                                                  logic [TIME_W-1:0] now);
        fan_speed_t  res;
        logic [31:0] scaled;
        logic [31:0] dt;
        longint      delta;
        longint      alpha;
        longint      lag_step;
        longint      slew_cap;
        longint      nv;
        res.channel = ch;
        res.rpm     = '0;
        if (ch >= NUM_CHANNELS_DEF)
            return res;
        scaled = 32'(raw);
        if (raw != 0 && raw < unit_thr)
            scaled = 32'(raw) * 32'(unit_mult);
        if (scaled > 32'hFFFF)
            scaled = 32'hFFFF;
        dt = now - stamp_mem[ch];
        if (scaled < 32'(zero_floor))
        begin
            speed_mem[ch] = '0;
            stamp_mem[ch] = now;
            seen_mem[ch]  = 1'b1;
        end
        else if (!seen_mem[ch] || dt > 32'(reload_gap))
        begin
            speed_mem[ch] = scaled[RPM_W-1:0];
            stamp_mem[ch] = now;
            seen_mem[ch]  = 1'b1;
        end
        else if (dt != 0)
        begin
            delta = longint'(scaled) - longint'(speed_mem[ch]);
            if (delta != 0)
            begin
                alpha    = (longint'(dt) << FRAC_BITS) / (longint'(lag_tau_ms) + longint'(dt));
                lag_step = (delta * alpha) >>> FRAC_BITS;
                if (lag_step == 0)
                    lag_step = (delta > 0) ? 1 : -1;
                slew_cap = (longint'(slew_rate) * longint'(dt)) / rlsf_pkg::LIM_DIVISOR;
                if (slew_cap < 1)
                    slew_cap = 1;
                if (lag_step > slew_cap)
                    lag_step = slew_cap;
                else if (lag_step < -slew_cap)
                    lag_step = -slew_cap;
                nv = longint'(speed_mem[ch]) + lag_step;
                if (nv < 0)
                    nv = 0;
                if (nv > 65535)
                    nv = 65535;
                speed_mem[ch] = nv[RPM_W-1:0];
            end
            stamp_mem[ch] = now;
        end
        res.rpm = speed_mem[ch];
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [RPM_W-1:0] pick_raw(logic [CHANNEL_W-1:0] ch);
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            v = int'(speed_mem[ch]) + int'($urandom_range(0, 600)) - 300;
            if (v < 0)
                v = 0;
            if (v > 65535)
                v = 65535;
            return v[RPM_W-1:0];
        end
        if (r < 60)
            return RPM_W'($urandom_range(0, 65535));
        if (r < 78)
            return RPM_W'($urandom_range(0, int'(unit_thr)));
        return RPM_W'($urandom_range(0, 4000));
    endfunction

    function automatic logic [TIME_W-1:0] pick_time(logic [CHANNEL_W-1:0] ch);
        int r;
        int span;
        r    = $urandom_range(0, 99);
        span = (reload_gap < 16'd3000) ? int'(reload_gap) : 3000;
        if (r < 6)
            return stamp_mem[ch];
        if (r < 85)
            return stamp_mem[ch] + TIME_W'($urandom_range(1, span));
        if (r < 93)
            return stamp_mem[ch] + TIME_W'(reload_gap) + TIME_W'($urandom_range(1, 2000));
        return TIME_W'($urandom());
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            rlsf_pkg::REG_LAG_TAU:    lag_tau_ms = data;
            rlsf_pkg::REG_SLEW:       slew_rate  = data;
            rlsf_pkg::REG_RELOAD_GAP: reload_gap = data;
            rlsf_pkg::REG_UNIT_THR:   unit_thr   = data;
            rlsf_pkg::REG_UNIT_MULT:  unit_mult  = data[MULT_W-1:0];
            rlsf_pkg::REG_ZERO_FLOOR: zero_floor = data;
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [15:0] tau, input logic [15:0] slew,
                            input logic [15:0] gap, input logic [15:0] thr,
                            input logic [15:0] mult, input logic [15:0] floor_rpm);
        write_reg(rlsf_pkg::REG_LAG_TAU, tau);
        write_reg(rlsf_pkg::REG_SLEW, slew);
        write_reg(rlsf_pkg::REG_RELOAD_GAP, gap);
        write_reg(rlsf_pkg::REG_UNIT_THR, thr);
        write_reg(rlsf_pkg::REG_UNIT_MULT, mult);
        write_reg(rlsf_pkg::REG_ZERO_FLOOR, floor_rpm);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_reading(input logic [CHANNEL_W-1:0] ch, input logic [RPM_W-1:0] raw,
                                input logic [TIME_W-1:0] now);
        int n;
        n = src_calm ? 0 : pick_gap();
        if (n > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, now, raw, ch};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_speeds.push_back(filter_reading(ch, raw, now));
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_speeds.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_defaults();
        push_reading(3'd0, 16'd3000, 32'd100);
        push_reading(3'd0, 16'd4000, 32'd200);
        push_reading(3'd0, 16'hFFFF, 32'd300);
        push_reading(3'd0, 16'd9000, 32'd300);
        push_reading(3'd0, speed_mem[0], 32'd400);
        push_reading(3'd0, speed_mem[0] + 16'd1, 32'd401);
        push_reading(3'd0, speed_mem[0] - 16'd2, 32'd402);
        push_reading(3'd0, 16'd600, 32'd1402);
        push_reading(3'd0, 16'd2500, 32'd7000);
        push_reading(3'd0, 16'd1200, 32'd6000);
        push_reading(3'd1, 16'd20, 32'd50);
        push_reading(3'd1, 16'd499, 32'd150);
        push_reading(3'd1, 16'd0, 32'd250);
        push_reading(3'd2, 16'd8000, 32'hFFFF_FFF0);
        push_reading(3'd2, 16'd9000, 32'h0000_0010);
        push_reading(3'd7, 16'hFFFF, 32'hFFFF_FFFF);
        wait_idle();
    endtask

    task automatic test_high_extremes();
        set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFF00 | 16'd255, 16'd0);
        push_reading(3'd3, 16'hFFFE, 32'd1000);
        push_reading(3'd3, 16'd1, 32'd66535);
        push_reading(3'd4, 16'd0, 32'd0);
        push_reading(3'd4, 16'd1, 32'd1);
        wait_idle();
    endtask

    task automatic test_low_extremes();
        set_regs(16'd0, 16'd1, 16'd1, 16'd0, 16'd1, 16'd0);
        push_reading(3'd5, 16'd40000, 32'd10);
        push_reading(3'd5, 16'd100, 32'd11);
        push_reading(3'd5, 16'd100, 32'd13);
        wait_idle();
        write_reg(rlsf_pkg::REG_ZERO_FLOOR, 16'hFFFF);
        cfg_valid <= 1'b0;
        push_reading(3'd6, 16'hFFFE, 32'd20);
        push_reading(3'd6, 16'hFFFF, 32'd21);
        wait_idle();
    endtask

    task automatic test_spare_index();
        set_regs(rlsf_pkg::LAG_TAU_RESET, rlsf_pkg::SLEW_RESET, rlsf_pkg::RELOAD_GAP_RESET,
                 rlsf_pkg::UNIT_THR_RESET, 16'(rlsf_pkg::UNIT_MULT_RESET),
                 rlsf_pkg::ZERO_FLOOR_RESET);
        @(posedge clk);
        write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom()));
        write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom()));
        cfg_valid <= 1'b0;
        push_reading(3'd1, 16'd30, stamp_mem[1] + 32'd100);
        push_reading(3'd1, 16'd3500, stamp_mem[1] + 32'd900);
        wait_idle();
    endtask

    task automatic test_random();
        logic [CHANNEL_W-1:0] ch;
        logic [RPM_W-1:0]     raw;
        for (int phase = 0; phase < 5; phase++)
        begin
            set_regs((phase == 4) ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 3000)),
                     16'($urandom_range(1, 65535)),
                     16'($urandom_range(200, 65535)),
                     16'($urandom_range(0, 1000)),
                     {8'($urandom()), 8'($urandom_range(1, 255))},
                     16'($urandom_range(0, 300)));
            src_calm  = ($urandom_range(0, 3) == 0);
            sink_calm = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < 130; i++)
            begin
                if ($urandom_range(0, 29) == 0)
                    src_calm = !src_calm;
                if ($urandom_range(0, 29) == 0)
                    sink_calm = !sink_calm;
                ch  = CHANNEL_W'($urandom_range(0, NUM_CHANNELS_DEF - 1));
                raw = pick_raw(ch);
                push_reading(ch, raw, pick_time(ch));
            end
            wait_idle();
        end
    endtask

    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            n = sink_calm ? 0 : pick_gap();
            if (n > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        fan_speed_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_speeds.size() == 0)
            begin
                $error("unexpected transfer: out_channel %0d filtered_rpm %0d",
                       m_axis_tdata[2:0], m_axis_tdata[18:3]);
                errors++;
            end
            else
            begin
                want = pending_speeds.pop_front();
                if (m_axis_tdata[2:0] !== want.channel)
                begin
                    $error("out_channel: expected %0d, got %0d", want.channel, m_axis_tdata[2:0]);
                    errors++;
                end
                if (m_axis_tdata[18:3] !== want.rpm)
                begin
                    $error("filtered_rpm: expected %0d, got %0d", want.rpm, m_axis_tdata[18:3]);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        clear_filters();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_defaults();
        test_high_extremes();
        test_low_extremes();
        test_spare_index();
        test_random();
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: rpm_lag_slew_filter.f
rtl/rlsf_pkg.sv
rtl/rpm_lag_slew_filter.sv
sim/tb.sv
